// ----- sv/nfas_pkg.sv -----
// Package: shared types and constants for the NFA active-set step unit.
package nfas_pkg;

  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 6;
  localparam int MASK_W  = 64;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_LABEL = 2'd1,
    CMD_EDGE  = 2'd2,
    CMD_CLEAR = 2'd3
  } nfas_cmd_t;

  // Decoded item broadcast to the state cells; strobes are already gated by accept.
  typedef struct packed {
    logic              step;
    logic              set_label;
    logic              set_edge;
    logic              clear;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  from;
    logic [IDX_W-1:0]  to;
    logic              from_ok;
    logic              to_ok;
  } nfas_ctl_t;

endpackage

// ----- sv/nfas_if.sv -----
// Interfaces: valid/ready channels for input items and result items.
`default_nettype none

interface nfas_in_if;
  import nfas_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [CHAR_W-1:0] char_value;
  logic [IDX_W-1:0]  from_state;
  logic [IDX_W-1:0]  to_state;

  modport source (output valid, command, char_value, from_state, to_state, input ready);
  modport sink   (input valid, command, char_value, from_state, to_state, output ready);
endinterface

interface nfas_out_if;
  import nfas_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] active_mask;

  modport source (output valid, active_mask, input ready);
  modport sink   (input valid, active_mask, output ready);
endinterface

`default_nettype wire

// ----- sv/nfa_active_set_step_unit.sv -----
// Top level: NFA active-set step unit, a row of state cells plus item handshake.
//
// Use: items arrive on in_ch (command, char_value, from_state, to_state) and
// each one yields exactly one result on out_ch: the 64-bit active_mask that
// holds after the item. Bits at or above NUM_STATES read zero.
// Commands: step on a character, load a state label, set an edge, or clear
// all edges and reset the active set to the start state (labels are kept).
// Label/edge commands with an out-of-range index change nothing.
// Timing: a result is valid in the cycle after its item is accepted. One item
// per cycle is sustained while out_ch.ready stays high; every state cell
// evaluates its label match and predecessor OR combinationally as the item is accepted.
// Stall: the result is held in the cells' active bits; in_ch.ready is low
// while a result waits and out_ch.ready is low, so nothing is overwritten.
// Reset (synchronous, rst_n low): labels zero, no edges, only state 0
// active, no result pending.
`default_nettype none

module nfa_active_set_step_unit
  import nfas_pkg::*;
#(
  parameter int NUM_STATES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nfas_in_if.sink     in_ch,
  nfas_out_if.source  out_ch
);

  localparam logic [IDX_W:0] NS_LIM = (IDX_W+1)'(NUM_STATES);

  logic                  out_valid_r, out_valid_nxt;
  logic                  in_acc, out_acc;
  nfas_ctl_t             ctl;
  nfas_cmd_t             cmd;
  logic [NUM_STATES-1:0] act_vec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;
  assign cmd         = nfas_cmd_t'(in_ch.command);

  always_comb begin
    ctl.step      = 1'b0;
    ctl.set_label = 1'b0;
    ctl.set_edge  = 1'b0;
    ctl.clear     = 1'b0;
    ctl.ch        = in_ch.char_value;
    ctl.from      = in_ch.from_state;
    ctl.to        = in_ch.to_state;
    ctl.from_ok   = {1'b0, in_ch.from_state} < NS_LIM;
    ctl.to_ok     = {1'b0, in_ch.to_state} < NS_LIM;
    if (in_acc) begin
      unique case (cmd)
        CMD_STEP:  ctl.step      = 1'b1;
        CMD_LABEL: ctl.set_label = 1'b1;
        CMD_EDGE:  ctl.set_edge  = 1'b1;
        CMD_CLEAR: ctl.clear     = 1'b1;
        default:   ctl.step      = 1'b0;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
    nfas_cell #(
      .NUM_STATES (NUM_STATES),
      .IDX        (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .active (act_vec),
      .act    (act_vec[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.active_mask = MASK_W'(act_vec);

  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    act_vec[0])
    else $error("start state not active");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("no result after accepted item");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(act_vec))
    else $error("active set changed without an item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_acc)
    else $error("item accepted over a pending result");

endmodule

`default_nettype wire

// ----- sv/nfas_cell.sv -----
// State cell: one automaton state with its label, predecessor column and active bit.
`default_nettype none

module nfas_cell
  import nfas_pkg::*;
#(
  parameter int NUM_STATES = 64,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire nfas_ctl_t             ctl,
  input  wire logic [NUM_STATES-1:0] active,
  output logic                       act
);

  localparam int  IW       = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam logic IS_START = (IDX == 0);

  logic [CHAR_W-1:0]     label_r, label_nxt;
  logic [NUM_STATES-1:0] pred_r, pred_nxt;
  logic                  act_r, act_nxt;
  logic                  hit;

  // pred_r[f] set means an edge f -> this state
  assign hit = (label_r == ctl.ch) && (|(pred_r & active));

  always_comb begin
    label_nxt = label_r;
    pred_nxt  = pred_r;
    act_nxt   = act_r;
    if (ctl.set_label && ctl.from_ok && (ctl.from == IDX_W'(IDX))) begin
      label_nxt = ctl.ch;
    end
    if (ctl.set_edge && ctl.from_ok && ctl.to_ok && (ctl.to == IDX_W'(IDX))) begin
      pred_nxt[ctl.from[IW-1:0]] = 1'b1;
    end
    if (ctl.clear) begin
      pred_nxt = '0;
      act_nxt  = IS_START;
    end
    if (ctl.step) begin
      act_nxt = IS_START | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= '0;
      pred_r  <= '0;
      act_r   <= IS_START;
    end else begin
      label_r <= label_nxt;
      pred_r  <= pred_nxt;
      act_r   <= act_nxt;
    end
  end

  assign act = act_r;

endmodule

`default_nettype wire

// ----- dv/tb_nfa_active_set_step_unit.sv -----
// Testbench: NFA active-set step unit, directed graph/step table then random automata.
`default_nettype none

module tb_nfa_active_set_step_unit;
  import nfas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STATES = 64;
  localparam int RAND_ITEMS = 1300;
  localparam logic [MASK_W-1:0] STATE_MASK =
    (NUM_STATES >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << NUM_STATES) - 64'd1);
  localparam logic [MASK_W-1:0] START_ONLY = 64'd1;
  localparam logic [MASK_W-1:0] START_LAST = 64'h8000_0000_0000_0001;

  typedef struct packed {
    nfas_cmd_t         cmd;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  from;
    logic [IDX_W-1:0]  to;
    logic              typed;
    logic [MASK_W-1:0] mask;
  } graph_row_t;

  localparam int NUM_ROWS = 25;
  localparam graph_row_t GRAPH_ROWS [NUM_ROWS] = '{
    '{CMD_STEP,  8'h00,  6'd0,  6'd0, 1'b1, START_ONLY},
    '{CMD_STEP,  8'hFF, 6'd63, 6'd63, 1'b1, START_ONLY},
    '{CMD_LABEL, 8'hFF, 6'd63,  6'd0, 1'b1, START_ONLY},
    '{CMD_LABEL, 8'h61,  6'd1, 6'd63, 1'b1, START_ONLY},
    '{CMD_LABEL, 8'h62,  6'd2,  6'd0, 1'b1, START_ONLY},
    '{CMD_EDGE,  8'hAA,  6'd0,  6'd1, 1'b1, START_ONLY},
    '{CMD_EDGE,  8'h00,  6'd1,  6'd2, 1'b1, START_ONLY},
    '{CMD_EDGE,  8'h55,  6'd2, 6'd63, 1'b1, START_ONLY},
    '{CMD_STEP,  8'h61, 6'd17, 6'd42, 1'b1, 64'd3},
    '{CMD_STEP,  8'h62,  6'd0,  6'd0, 1'b1, 64'd5},
    '{CMD_STEP,  8'hFF,  6'd0,  6'd0, 1'b1, START_LAST},
    '{CMD_STEP,  8'h00,  6'd0,  6'd0, 1'b1, START_ONLY},
    '{CMD_EDGE,  8'h00,  6'd0,  6'd0, 1'b1, START_ONLY},
    '{CMD_EDGE,  8'h00, 6'd63, 6'd63, 1'b1, START_ONLY},
    '{CMD_EDGE,  8'h00,  6'd0, 6'd63, 1'b1, START_ONLY},
    '{CMD_STEP,  8'hFF,  6'd0,  6'd0, 1'b1, START_LAST},
    // 63 now reached from both 0 and 63
    '{CMD_STEP,  8'hFF,  6'd0,  6'd0, 1'b1, START_LAST},
    '{CMD_LABEL, 8'h61,  6'd3,  6'd0, 1'b0, '0},
    '{CMD_EDGE,  8'h00,  6'd0,  6'd3, 1'b0, '0},
    '{CMD_STEP,  8'h61,  6'd0,  6'd0, 1'b0, '0},
    '{CMD_CLEAR, 8'hFF, 6'd63, 6'd63, 1'b1, START_ONLY},
    // labels survive the clear, edges do not
    '{CMD_STEP,  8'h61,  6'd0,  6'd0, 1'b1, START_ONLY},
    '{CMD_EDGE,  8'h00,  6'd0,  6'd1, 1'b0, '0},
    '{CMD_STEP,  8'h61,  6'd0,  6'd0, 1'b0, '0},
    '{CMD_STEP,  8'h00,  6'd0,  6'd0, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  nfas_in_if  in_ch ();
  nfas_out_if out_ch ();

  nfa_active_set_step_unit #(.NUM_STATES(NUM_STATES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the automaton
  logic [CHAR_W-1:0] label_mem [NUM_STATES];
  logic [MASK_W-1:0] succ_rows [NUM_STATES];
  logic [MASK_W-1:0] live_states;

  logic [MASK_W-1:0] pending_masks [$];
  int unsigned       mask_errors;
  int unsigned       items_sent;
  bit                steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [MASK_W-1:0] next_active_mask(nfas_cmd_t cmd,
      logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] from, logic [IDX_W-1:0] to);
    logic [MASK_W-1:0] hit;
    logic [MASK_W-1:0] reach;
    hit   = '0;
    reach = '0;
    case (cmd)
      CMD_STEP: begin
        for (int s = 0; s < NUM_STATES; s++) begin
          if (label_mem[s] == ch) hit[s] = 1'b1;
          if (live_states[s]) reach |= succ_rows[s];
        end
        live_states = ((reach & hit) | START_ONLY) & STATE_MASK;
      end
      CMD_LABEL: begin
        if (int'(from) < NUM_STATES) label_mem[from] = ch;
      end
      CMD_EDGE: begin
        if (int'(from) < NUM_STATES && int'(to) < NUM_STATES)
          succ_rows[from][to] = 1'b1;
      end
      default: begin
        for (int s = 0; s < NUM_STATES; s++) succ_rows[s] = '0;
        live_states = START_ONLY;
      end
    endcase
    return live_states & STATE_MASK;
  endfunction

  task automatic send_item(nfas_cmd_t cmd, logic [CHAR_W-1:0] ch,
      logic [IDX_W-1:0] from, logic [IDX_W-1:0] to,
      logic typed = 1'b0, logic [MASK_W-1:0] typed_mask = '0);
    logic [MASK_W-1:0] predicted;
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.char_value <= ch;
    in_ch.from_state <= from;
    in_ch.to_state   <= to;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = next_active_mask(cmd, ch, from, to);
    pending_masks.push_back(typed ? typed_mask : predicted);
    items_sent++;
  endtask

  // Result side: check each item, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_masks.size() == 0) begin
          $error("active_mask: unexpected item, actual %h", out_ch.active_mask);
          mask_errors++;
        end else begin
          logic [MASK_W-1:0] want;
          want = pending_masks.pop_front();
          if (out_ch.active_mask !== want) begin
            $error("active_mask: expected %h, actual %h", want, out_ch.active_mask);
            mask_errors++;
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    logic [IDX_W-1:0]  pool [12];
    logic [CHAR_W-1:0] base;
    int                npool;
    int                nedges;
    int                nsteps;

    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_STEP;
    in_ch.char_value = '0;
    in_ch.from_state = '0;
    in_ch.to_state   = '0;
    rst_n            = 1'b0;
    mask_errors      = 0;
    items_sent       = 0;
    steady           = 1'b0;
    for (int s = 0; s < NUM_STATES; s++) begin
      label_mem[s] = '0;
      succ_rows[s] = '0;
    end
    live_states = START_ONLY;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++)
      send_item(GRAPH_ROWS[r].cmd, GRAPH_ROWS[r].ch, GRAPH_ROWS[r].from,
                GRAPH_ROWS[r].to, GRAPH_ROWS[r].typed, GRAPH_ROWS[r].mask);

    // Random automata: small alphabet so steps keep finding live paths
    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      steady = (items_sent >= 500 && items_sent < 800);
      // now and then keep the old graph and pile more edges on it
      if ($urandom_range(0, 7) != 0)
        send_item(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)));
      npool   = $urandom_range(3, 12);
      base    = CHAR_W'($urandom_range(0, 255));
      pool[0] = '0;
      for (int k = 1; k < npool; k++) pool[k] = IDX_W'($urandom_range(1, 63));
      for (int k = 0; k < npool; k++)
        send_item(CMD_LABEL, CHAR_W'(base + $urandom_range(0, 3)), pool[k],
                  IDX_W'($urandom_range(0, 63)));
      nedges = $urandom_range(npool, 3 * npool);
      for (int k = 0; k < nedges; k++)
        send_item(CMD_EDGE, CHAR_W'($urandom_range(0, 255)),
                  pool[$urandom_range(0, npool - 1)],
                  pool[$urandom_range(0, npool - 1)]);
      nsteps = $urandom_range(10, 40);
      for (int k = 0; k < nsteps; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(nfas_cmd_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                    IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)));
        else if ($urandom_range(0, 9) == 0)
          send_item(CMD_STEP, CHAR_W'($urandom_range(0, 255)),
                    IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)));
        else
          send_item(CMD_STEP, CHAR_W'(base + $urandom_range(0, 3)),
                    IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)));
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_masks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mask_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
